// ===== rtl/core/sbh_pkg.sv =====
// Shared types, constants and helpers of the symbol and bigram histogram.
package sbh_pkg;

    localparam int SYMBOL_BITS = 8;
    localparam int COUNT_BITS  = 32;
    localparam int BIGRAM_BITS = 2 * SYMBOL_BITS;
    localparam int SYM_DEPTH   = 1 << SYMBOL_BITS;
    localparam int BIG_DEPTH   = 1 << BIGRAM_BITS;

    // Port widths fixed by the item format.
    localparam int CMD_BITS   = 2;
    localparam int BYTE_BITS  = 8;
    localparam int INDEX_BITS = 16;
    localparam int OUT_BITS   = 32;

    // Queue sizing, shared by the request and result queues.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [CMD_BITS-1:0] {
        CMD_COUNT  = 2'd0,
        CMD_READ   = 2'd1,
        CMD_CLEAR  = 2'd2,
        CMD_TOTALS = 2'd3
    } t_cmd;

    typedef logic [SYMBOL_BITS-1:0] t_sym;
    typedef logic [BIGRAM_BITS-1:0] t_big;
    typedef logic [COUNT_BITS-1:0]  t_count;
    typedef logic [OUT_BITS-1:0]    t_out;

    // Classified request, as held between front and back.
    typedef struct packed {
        t_cmd cmd;
        t_sym sym;   // symbol to count, or symbol to read
        t_big idx;   // bigram to read
    } t_req;

    typedef struct packed {
        t_out symbol_count;
        t_out overlap_count;
        t_out nonoverlap_count;
        t_out text_length;
        t_out overlap_total;
        t_out nonoverlap_total;
    } t_result;

    function automatic t_count sat_inc(input t_count v);
        return (v == '1) ? v : v + COUNT_BITS'(1);
    endfunction

    // Low output bits of a counter, zero-extended when the counter is narrower.
    function automatic t_out to_out(input t_count v);
        logic [63:0] w;
        w = 64'(v);
        return w[OUT_BITS-1:0];
    endfunction

endpackage

// ===== rtl/core/symbol_and_bigram_histogram.sv =====
// Top level of the symbol and bigram histogram.
//
// Counts text bytes into three histograms held in on-chip memory: one count per
// symbol, one per overlapping bigram (previous byte, current byte) and one per
// non-overlapping bigram whose first byte sits at an even position, along with
// the text length and both bigram totals; all counters saturate. Requests enter
// through a queue-like port (push/full) and every request yields exactly one
// result on the output queue (empty/pop), in request order. A count or an
// index read passes through the back-end states S_IDLE, which reads the count
// memories (registered read data), and S_EXEC, which writes the incremented
// counts and posts the result; the back end takes no new request until it has
// finished the current one. A totals read posts its result from S_IDLE. A
// clear posts its result at once and then sweeps the stores, one bigram entry
// per cycle, taking no further request until the sweep ends; the same sweep
// runs after reset. The front queue keeps accepting up to two requests while
// the back end is busy, and the two-entry result queue lets a finished result
// wait for pop without halting the next request.
module symbol_and_bigram_histogram (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [sbh_pkg::CMD_BITS-1:0]      i_command,
    input  logic [sbh_pkg::BYTE_BITS-1:0]     i_text_byte,
    input  logic [sbh_pkg::INDEX_BITS-1:0]    i_read_index,
    output logic                              empty,
    input  logic                              pop,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_symbol_count,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_overlap_count,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_nonoverlap_count,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_text_length,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_overlap_total,
    output logic [sbh_pkg::OUT_BITS-1:0]      o_nonoverlap_total
);
    import sbh_pkg::*;

    // request queue to back end
    logic    req_valid;
    t_req    req;
    logic    req_take;

    // back end to result queue
    logic    res_push;
    t_result res;
    logic    res_full;
    t_result res_head;

    // Accept and classify requests; hold them until the back end is free.
    sbh_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_push       (push),
        .o_full       (full),
        .i_command    (i_command),
        .i_text_byte  (i_text_byte),
        .i_read_index (i_read_index),
        .o_valid      (req_valid),
        .o_req        (req),
        .i_take       (req_take)
    );

    // Carry out counts, reads and clears against the stores.
    sbh_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (req_valid),
        .i_req       (req),
        .o_take      (req_take),
        .i_out_full  (res_full),
        .o_res_push  (res_push),
        .o_res       (res)
    );

    // Hold finished results until popped.
    sbh_outq u_outq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (res_push),
        .i_data  (res),
        .o_full  (res_full),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (res_head)
    );

    assign o_symbol_count     = res_head.symbol_count;
    assign o_overlap_count    = res_head.overlap_count;
    assign o_nonoverlap_count = res_head.nonoverlap_count;
    assign o_text_length      = res_head.text_length;
    assign o_overlap_total    = res_head.overlap_total;
    assign o_nonoverlap_total = res_head.nonoverlap_total;

endmodule

// ===== rtl/core/sbh_front.sv =====
// Front end: accepts requests, classifies them and queues them for the back end.
module sbh_front (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_push,
    output logic                                  o_full,
    input  logic [sbh_pkg::CMD_BITS-1:0]          i_command,
    input  logic [sbh_pkg::BYTE_BITS-1:0]         i_text_byte,
    input  logic [sbh_pkg::INDEX_BITS-1:0]        i_read_index,
    output logic                                  o_valid,
    output sbh_pkg::t_req                         o_req,
    input  logic                                  i_take
);
    import sbh_pkg::*;

    t_req                 r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt;
    t_req                 req_in;
    logic                 wr;
    logic                 rd;

    // Pick the symbol field by command: counted byte or symbol to read.
    always_comb begin
        req_in.cmd = t_cmd'(i_command);
        req_in.idx = i_read_index[BIGRAM_BITS-1:0];
        if (req_in.cmd == CMD_COUNT) begin
            req_in.sym = i_text_byte[SYMBOL_BITS-1:0];
        end else begin
            req_in.sym = i_read_index[SYMBOL_BITS-1:0];
        end
    end

    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_req   = r_q[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_take && o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr) begin
                r_q[r_wr_ptr] <= req_in;
                r_wr_ptr      <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            r_cnt <= r_cnt + QCNT_BITS'(wr) - QCNT_BITS'(rd);
        end
    end

endmodule

// ===== rtl/core/sbh_outq.sv =====
// Result queue: holds finished results until the consumer pops them.
module sbh_outq (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  sbh_pkg::t_result i_data,
    output logic             o_full,
    input  logic             i_pop,
    output logic             o_empty,
    output sbh_pkg::t_result o_data
);
    import sbh_pkg::*;

    t_result              r_q [QUEUE_DEPTH];
    logic [QPTR_BITS-1:0] r_wr_ptr;
    logic [QPTR_BITS-1:0] r_rd_ptr;
    logic [QCNT_BITS-1:0] r_cnt;
    logic                 wr;
    logic                 rd;

    assign o_full  = (r_cnt == QCNT_BITS'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_q[r_rd_ptr];
    assign wr      = i_push && !o_full;
    assign rd      = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (wr) begin
                r_q[r_wr_ptr] <= i_data;
                r_wr_ptr      <= r_wr_ptr + QPTR_BITS'(1);
            end
            if (rd) begin
                r_rd_ptr <= r_rd_ptr + QPTR_BITS'(1);
            end
            r_cnt <= r_cnt + QCNT_BITS'(wr) - QCNT_BITS'(rd);
        end
    end

endmodule

// ===== rtl/core/sbh_back.sv =====
// Back end: count memories, totals, clearing sweep and result generation.
module sbh_back (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_req_valid,
    input  sbh_pkg::t_req    i_req,
    output logic             o_take,
    input  logic             i_out_full,
    output logic             o_res_push,
    output sbh_pkg::t_result o_res
);
    import sbh_pkg::*;

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_count sym_mem [SYM_DEPTH];
    t_count ov_mem  [BIG_DEPTH];
    t_count no_mem  [BIG_DEPTH];

    t_state r_state, n_state;
    t_big   r_sweep, n_sweep;
    t_sym   r_prev, n_prev;
    logic   r_odd, n_odd;
    t_count r_len, n_len;
    t_count r_ov_sum, n_ov_sum;
    t_count r_no_sum, n_no_sum;
    t_cmd   r_cmd, n_cmd;
    t_sym   r_sym_addr, n_sym_addr;
    t_big   r_big_addr, n_big_addr;

    t_count r_sym_rd;
    t_count r_ov_rd;
    t_count r_no_rd;

    t_big   big_raddr;
    logic   sym_we, ov_we, no_we;
    t_sym   sym_waddr;
    t_big   big_waddr;
    t_count sym_wdata, ov_wdata, no_wdata;

    // Counting addresses the bigram formed with the previous byte.
    assign big_raddr = (i_req.cmd == CMD_COUNT) ? {r_prev, i_req.sym} : i_req.idx;

    always_comb begin
        n_state    = r_state;
        n_sweep    = r_sweep;
        n_prev     = r_prev;
        n_odd      = r_odd;
        n_len      = r_len;
        n_ov_sum   = r_ov_sum;
        n_no_sum   = r_no_sum;
        n_cmd      = r_cmd;
        n_sym_addr = r_sym_addr;
        n_big_addr = r_big_addr;
        o_take     = 1'b0;
        o_res_push = 1'b0;
        o_res      = '0;
        sym_we     = 1'b0;
        ov_we      = 1'b0;
        no_we      = 1'b0;
        sym_waddr  = r_sym_addr;
        big_waddr  = r_big_addr;
        sym_wdata  = '0;
        ov_wdata   = '0;
        no_wdata   = '0;

        case (r_state)
            S_CLEAR: begin
                // zero one entry of every store per cycle
                sym_we    = 1'b1;
                ov_we     = 1'b1;
                no_we     = 1'b1;
                sym_waddr = r_sweep[SYMBOL_BITS-1:0];
                big_waddr = r_sweep;
                n_sweep   = r_sweep + BIGRAM_BITS'(1);
                if (r_sweep == '1) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req_valid && !i_out_full) begin
                    o_take     = 1'b1;
                    n_cmd      = i_req.cmd;
                    n_sym_addr = i_req.sym;
                    n_big_addr = big_raddr;
                    case (i_req.cmd)
                        CMD_CLEAR: begin
                            n_prev     = '0;
                            n_odd      = 1'b0;
                            n_len      = '0;
                            n_ov_sum   = '0;
                            n_no_sum   = '0;
                            n_sweep    = '0;
                            n_state    = S_CLEAR;
                            o_res_push = 1'b1;
                        end
                        CMD_TOTALS: begin
                            o_res_push = 1'b1;
                        end
                        default: begin
                            n_state = S_EXEC;
                        end
                    endcase
                end
            end
            S_EXEC: begin
                o_res_push = 1'b1;
                n_state    = S_IDLE;
                if (r_cmd == CMD_COUNT) begin
                    sym_we    = 1'b1;
                    sym_wdata = sat_inc(r_sym_rd);
                    if (r_len != '0) begin
                        ov_we    = 1'b1;
                        ov_wdata = sat_inc(r_ov_rd);
                        n_ov_sum = sat_inc(r_ov_sum);
                        // previous byte sat at an even position
                        if (r_odd) begin
                            no_we    = 1'b1;
                            no_wdata = sat_inc(r_no_rd);
                            n_no_sum = sat_inc(r_no_sum);
                        end
                    end
                    n_prev = r_sym_addr;
                    n_odd  = ~r_odd;
                    n_len  = sat_inc(r_len);
                end else begin
                    o_res.symbol_count     = to_out(r_sym_rd);
                    o_res.overlap_count    = to_out(r_ov_rd);
                    o_res.nonoverlap_count = to_out(r_no_rd);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        o_res.text_length      = to_out(n_len);
        o_res.overlap_total    = to_out(n_ov_sum);
        o_res.nonoverlap_total = to_out(n_no_sum);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_sweep  <= '0;
            r_prev   <= '0;
            r_odd    <= 1'b0;
            r_len    <= '0;
            r_ov_sum <= '0;
            r_no_sum <= '0;
        end else begin
            r_state  <= n_state;
            r_sweep  <= n_sweep;
            r_prev   <= n_prev;
            r_odd    <= n_odd;
            r_len    <= n_len;
            r_ov_sum <= n_ov_sum;
            r_no_sum <= n_no_sum;
        end
        r_cmd      <= n_cmd;
        r_sym_addr <= n_sym_addr;
        r_big_addr <= n_big_addr;
    end

    // Count memories: one write port, one registered read port each.
    always_ff @(posedge i_clk) begin
        if (sym_we) begin
            sym_mem[sym_waddr] <= sym_wdata;
        end
        r_sym_rd <= sym_mem[i_req.sym];
    end

    always_ff @(posedge i_clk) begin
        if (ov_we) begin
            ov_mem[big_waddr] <= ov_wdata;
        end
        r_ov_rd <= ov_mem[big_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (no_we) begin
            no_mem[big_waddr] <= no_wdata;
        end
        r_no_rd <= no_mem[big_raddr];
    end

    a_exec_one_cycle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EXEC) |=> (r_state == S_IDLE))
        else $error("execute state held for more than one cycle");

    a_overlap_le_length: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov_sum <= r_len)
        else $error("overlapping total exceeds text length");

    a_nonoverlap_le_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_no_sum <= r_ov_sum)
        else $error("non-overlapping total exceeds overlapping total");

    a_no_take_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> (!o_take && !o_res_push))
        else $error("request taken during clearing sweep");

endmodule

// ===== test/symbol_and_bigram_histogram_test.sv =====
// Self-checking regression of the symbol and bigram histogram, with its own count predictor.
module symbol_and_bigram_histogram_test;
    timeunit 1ns;
    timeprecision 1ps;

    import sbh_pkg::*;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic push    = 1'b0;
    logic pop     = 1'b0;
    t_cmd i_command = CMD_COUNT;
    logic [BYTE_BITS-1:0]  i_text_byte  = '0;
    logic [INDEX_BITS-1:0] i_read_index = '0;
    logic full;
    logic empty;
    t_out o_symbol_count;
    t_out o_overlap_count;
    t_out o_nonoverlap_count;
    t_out o_text_length;
    t_out o_overlap_total;
    t_out o_nonoverlap_total;

    symbol_and_bigram_histogram dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .push               (push),
        .full               (full),
        .i_command          (i_command),
        .i_text_byte        (i_text_byte),
        .i_read_index       (i_read_index),
        .empty              (empty),
        .pop                (pop),
        .o_symbol_count     (o_symbol_count),
        .o_overlap_count    (o_overlap_count),
        .o_nonoverlap_count (o_nonoverlap_count),
        .o_text_length      (o_text_length),
        .o_overlap_total    (o_overlap_total),
        .o_nonoverlap_total (o_nonoverlap_total)
    );

    // 10 ns clock.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predicted histogram state. The bigram stores are sparse: an absent
    // key reads as zero, and a clear simply empties them.
    // ------------------------------------------------------------------
    t_count symbol_hist [SYM_DEPTH];
    t_count overlap_hist [int];
    t_count nonoverlap_hist [int];
    t_sym   prev_symbol;
    t_count text_len;
    t_count overlap_sum;
    t_count nonoverlap_sum;
    bit     position_odd;   // parity of bytes since the last clear

    // Bigrams formed recently; reads aim at these so that they hit non-zero counts.
    t_big   recent_pairs [$];

    t_result predicted_results [$];

    int unsigned burst_left;
    int unsigned clears_left;
    int unsigned mismatch_count;
    int unsigned results_checked;
    int unsigned n_counted, n_reads, n_clears, n_totals;

    // Saturating increment: hold at all-ones.
    function automatic t_count bump(input t_count v);
        return (&v) ? v : v + 1'b1;
    endfunction

    function automatic void clear_histograms();
        foreach (symbol_hist[k]) symbol_hist[k] = '0;
        overlap_hist.delete();
        nonoverlap_hist.delete();
        prev_symbol    = '0;
        text_len       = '0;
        overlap_sum    = '0;
        nonoverlap_sum = '0;
        position_odd   = 1'b0;
    endfunction

    // Apply one request to the predicted state and return the result it must give.
    function automatic t_result histogram_predict(input t_cmd cmd,
                                                  input logic [BYTE_BITS-1:0] text_byte,
                                                  input logic [INDEX_BITS-1:0] idx);
        t_result r;
        t_sym    s;
        t_big    pair;
        int      key;
        r = '0;
        s = text_byte[SYMBOL_BITS-1:0];
        case (cmd)
            CMD_COUNT: begin
                symbol_hist[s] = bump(symbol_hist[s]);
                // The first byte after a clear has no predecessor, so forms no bigram.
                if (text_len != '0) begin
                    pair = {prev_symbol, s};
                    key  = int'(pair);
                    overlap_hist[key] = bump(overlap_hist.exists(key) ? overlap_hist[key] : '0);
                    overlap_sum = bump(overlap_sum);
                    // Odd parity now means the previous byte sat at an even position.
                    if (position_odd) begin
                        nonoverlap_hist[key] =
                            bump(nonoverlap_hist.exists(key) ? nonoverlap_hist[key] : '0);
                        nonoverlap_sum = bump(nonoverlap_sum);
                    end
                    recent_pairs.insert(recent_pairs.size(), pair);
                    if (recent_pairs.size() > 32) void'(recent_pairs.pop_front());
                end
                prev_symbol  = s;
                position_odd = !position_odd;
                text_len     = bump(text_len);
            end
            CMD_READ: begin
                key = int'(idx[BIGRAM_BITS-1:0]);
                r.symbol_count     = t_out'(symbol_hist[idx[SYMBOL_BITS-1:0]]);
                r.overlap_count    = overlap_hist.exists(key) ? t_out'(overlap_hist[key]) : '0;
                r.nonoverlap_count =
                    nonoverlap_hist.exists(key) ? t_out'(nonoverlap_hist[key]) : '0;
            end
            CMD_CLEAR: begin
                clear_histograms();
                recent_pairs.delete();
            end
            default: begin
                // Totals only: no state change, count fields stay zero.
            end
        endcase
        // Totals always reflect the state after the request took effect.
        r.text_length      = t_out'(text_len);
        r.overlap_total    = t_out'(overlap_sum);
        r.nonoverlap_total = t_out'(nonoverlap_sum);
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Request side: bursts of random length, random gaps between them,
    // and now and then a long burst with no idling at all.
    // ------------------------------------------------------------------
    task automatic send_request(input t_cmd cmd, input logic [BYTE_BITS-1:0] text_byte,
                                input logic [INDEX_BITS-1:0] idx);
        int unsigned gap;
        t_result     expected;
        if (burst_left == 0) begin
            gap = $urandom_range(1, 6);
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
            burst_left = ($urandom_range(0, 5) == 0) ? 48 : $urandom_range(1, 12);
        end
        push         <= 1'b1;
        i_command    <= cmd;
        i_text_byte  <= text_byte;
        i_read_index <= idx;
        // Hold the request until it is taken; a clear sweep keeps full high for long.
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        expected = histogram_predict(cmd, text_byte, idx);
        predicted_results.insert(predicted_results.size(), expected);
        burst_left--;
        case (cmd)
            CMD_COUNT: n_counted++;
            CMD_READ:  n_reads++;
            CMD_CLEAR: n_clears++;
            default:   n_totals++;
        endcase
    endtask

    // Mostly a small alphabet so that bigrams repeat; the rest across the whole byte range.
    function automatic logic [BYTE_BITS-1:0] pick_text_byte();
        logic [BYTE_BITS-1:0] alphabet [8];
        alphabet = '{8'h20, 8'h61, 8'h65, 8'h69, 8'h6e, 8'h6f, 8'h74, 8'hd0};
        if ($urandom_range(0, 9) < 7) return alphabet[$urandom_range(0, 7)];
        return BYTE_BITS'($urandom);
    endfunction

    function automatic logic [INDEX_BITS-1:0] pick_read_index();
        if (recent_pairs.size() != 0 && $urandom_range(0, 3) != 0)
            return recent_pairs[$urandom_range(0, recent_pairs.size() - 1)];
        return INDEX_BITS'($urandom);
    endfunction

    // ------------------------------------------------------------------
    // Result side: pop on a pattern whose mode is picked anew each time the phase
    // counter runs out - always ready, a random bit mask, or rarely ready.
    // ------------------------------------------------------------------
    logic [31:0] pop_mask  = '0;
    logic [5:0]  pop_phase = '0;
    logic [1:0]  pop_mode  = '0;

    always @(posedge i_clk) begin
        if (pop_phase == 0) begin
            pop_mode  <= 2'($urandom_range(0, 2));
            pop_mask  <= $urandom;
            pop_phase <= 6'd47;
        end else begin
            pop_phase <= pop_phase - 1'b1;
        end
        case (pop_mode)
            2'd0:    pop <= 1'b1;
            2'd1:    pop <= pop_mask[pop_phase[4:0]];
            default: pop <= ($urandom_range(0, 3) == 0);
        endcase
    end

    function automatic void check_field(input string name, input t_out want, input t_out got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d (0x%08h), got %0d (0x%08h)",
                     $time, name, want, want, got, got);
            mismatch_count++;
        end
    endfunction

    // Compare every popped result against the oldest prediction; values are
    // those from before the edge, as are pop and empty.
    always @(posedge i_clk) begin : result_check
        t_result want;
        if (i_rst_n && pop && !empty) begin
            if (predicted_results.size() == 0) begin
                $display("%0t: result popped with no request outstanding, length %0d",
                         $time, o_text_length);
                mismatch_count++;
            end else begin
                want = predicted_results.pop_front();
                results_checked++;
                check_field("symbol_count",     want.symbol_count,     o_symbol_count);
                check_field("overlap_count",    want.overlap_count,    o_overlap_count);
                check_field("nonoverlap_count", want.nonoverlap_count, o_nonoverlap_count);
                check_field("text_length",      want.text_length,      o_text_length);
                check_field("overlap_total",    want.overlap_total,    o_overlap_total);
                check_field("nonoverlap_total", want.nonoverlap_total, o_nonoverlap_total);
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Field extremes, every command, first byte, bigram parity and a clear.
    task automatic test_directed();
        // Totals straight after reset, with all-ones junk in the unused fields.
        send_request(CMD_TOTALS, 8'hff, 16'hffff);
        // 00 FF 00 FF FF: 00FF is non-overlapping twice, FF00 and FFFF only overlapping.
        send_request(CMD_COUNT, 8'h00, 16'hffff);
        send_request(CMD_COUNT, 8'hff, 16'h0000);
        send_request(CMD_COUNT, 8'h00, 16'hffff);
        send_request(CMD_COUNT, 8'hff, 16'h0000);
        send_request(CMD_COUNT, 8'hff, 16'hffff);
        send_request(CMD_READ, 8'hff, 16'h00ff);
        send_request(CMD_READ, 8'h00, 16'hff00);
        send_request(CMD_READ, 8'hff, 16'hffff);
        send_request(CMD_READ, 8'hff, 16'h0000);
        send_request(CMD_READ, 8'h00, 16'h5aa5);
        send_request(CMD_TOTALS, 8'h00, 16'h0000);
        // Clear with junk fields; everything must read back zero afterwards.
        send_request(CMD_CLEAR, 8'hab, 16'h1234);
        send_request(CMD_READ, 8'h00, 16'h00ff);
        // First byte after the clear must not pair with the last byte before it.
        send_request(CMD_COUNT, 8'h41, 16'h0000);
        send_request(CMD_READ, 8'h00, 16'hff41);
        send_request(CMD_COUNT, 8'h42, 16'h0000);
        send_request(CMD_COUNT, 8'h41, 16'h0000);
        send_request(CMD_COUNT, 8'h42, 16'h0000);
        send_request(CMD_READ, 8'h00, 16'h4142);
        send_request(CMD_READ, 8'h00, 16'h4241);
        send_request(CMD_TOTALS, 8'h55, 16'haaaa);
    endtask

    // Well-formed text with reads of recent bigrams and a clear half way through.
    task automatic test_text_stream(input int unsigned n);
        int unsigned r;
        for (int unsigned i = 0; i < n; i++) begin
            r = $urandom_range(0, 99);
            if (i == n / 2 && clears_left != 0) begin
                clears_left--;
                send_request(CMD_CLEAR, BYTE_BITS'($urandom), INDEX_BITS'($urandom));
            end else if (r < 70) begin
                send_request(CMD_COUNT, pick_text_byte(), INDEX_BITS'($urandom));
            end else if (r < 90) begin
                send_request(CMD_READ, BYTE_BITS'($urandom), pick_read_index());
            end else begin
                send_request(CMD_TOTALS, BYTE_BITS'($urandom), INDEX_BITS'($urandom));
            end
        end
    endtask

    // Any command with random field values (reads mostly of recent bigrams); clears are costly, so cap them.
    task automatic test_random_mix(input int unsigned n);
        t_cmd cmd;
        for (int unsigned i = 0; i < n; i++) begin
            cmd = t_cmd'($urandom_range(0, 3));
            if (cmd == CMD_CLEAR) begin
                if (clears_left != 0 && $urandom_range(0, 29) == 0) clears_left--;
                else cmd = CMD_COUNT;
            end
            send_request(cmd, BYTE_BITS'($urandom),
                         (cmd == CMD_READ) ? pick_read_index() : INDEX_BITS'($urandom));
        end
    endtask

    initial begin
        clear_histograms();
        burst_left      = 0;
        clears_left     = 2;
        mismatch_count  = 0;
        results_checked = 0;
        n_counted = 0;
        n_reads   = 0;
        n_clears  = 0;
        n_totals  = 0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_directed();
        test_text_stream(600);
        test_random_mix(230);

        // Drain: wait for every predicted result, then keep watching for strays.
        push <= 1'b0;
        while (predicted_results.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Covered %0d byte counts, %0d index reads, %0d totals reads, %0d clears;",
                 n_counted, n_reads, n_totals, n_clears);
        $display("%0d results compared field by field, %0d mismatches.",
                 results_checked, mismatch_count);
        if (mismatch_count == 0) begin
            $display("symbol_and_bigram_histogram regression: pass");
        end else begin
            $display("symbol_and_bigram_histogram regression: fail");
        end
        $finish;
    end

    // Watchdog: reset sweep plus a few clear sweeps need well under this.
    initial begin
        #20ms;
        $display("%0t: timeout with %0d results outstanding", $time, predicted_results.size());
        $display("symbol_and_bigram_histogram regression: fail");
        $finish;
    end

endmodule
